### rtl/sewa_pkg.sv
// Shared package for the subset enumerator core.
// Holds bus widths, opcode and register codes, saturation limits and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package sewa_pkg;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = 8;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_REWIND = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_LIMIT  = 2'd3;

  localparam logic [19:0] PROB_SUM_MAX = 20'hFFFFF;
  localparam logic [18:0] VAR_SUM_MAX  = 19'h7FFFF;
  localparam logic [15:0] WORD_MAX     = 16'hFFFF;

  typedef struct packed {
    logic capture;
    logic tbl_wr;
    logic rewind;
    logic clear_res;
    logic acc_start;
    logic acc_run;
    logic advance;
    logic pos_wr;
    logic offer;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       next_ok;
    logic       acc_done;
    logic       found;
    logic       wr_last;
    logic       out_free;
  } sta_t;

endpackage

### rtl/sewa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sewa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sewa_ctrl.sv
// Controller state machine for the subset enumerator.
// Depends on sewa_pkg for the command and status structs and opcodes.
`timescale 1ns / 1ps

module sewa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sewa_pkg::sta_t sta,
  output sewa_pkg::cmd_t cmd
);

  import sewa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_ACC    = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_RESULT;
        unique case (sta.op)
          OP_LOAD: begin
            cmd.tbl_wr    = 1'b1;
            cmd.clear_res = 1'b1;
          end
          OP_REWIND: begin
            cmd.rewind    = 1'b1;
            cmd.clear_res = 1'b1;
          end
          OP_NEXT: begin
            if (sta.next_ok) begin
              cmd.acc_start = 1'b1;
              state_nxt     = ST_ACC;
            end else begin
              cmd.clear_res = 1'b1;
            end
          end
          default: begin
            cmd.clear_res = 1'b1;
          end
        endcase
      end
      ST_ACC: begin
        cmd.acc_run = 1'b1;
        if (sta.acc_done) begin
          cmd.advance = 1'b1;
          state_nxt   = sta.found ? ST_WRITE : ST_RESULT;
        end
      end
      ST_WRITE: begin
        cmd.pos_wr = 1'b1;
        if (sta.wr_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.offer = 1'b1;
        if (sta.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/sewa_dp.sv
// Datapath for the subset enumerator: config registers, node table and
// position RAMs, accumulate pipeline, position update and output register.
// Depends on sewa_pkg and sewa_ram.
`timescale 1ns / 1ps

module sewa_dp #(
  parameter int MAX_NODES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sewa_pkg::cmd_t                       cmd,
  output sewa_pkg::sta_t                       sta,
  input  logic [sewa_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [sewa_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                 cfg_we,
  input  logic [sewa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sewa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sewa_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [sewa_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);

  import sewa_pkg::*;

  localparam int AW  = $clog2(MAX_NODES);
  localparam int PSW = 16 + $clog2(MAX_NODES + 1);
  localparam int VSW = 15 + $clog2(MAX_NODES + 1);

  // Configuration registers
  logic [4:0]  node_count_r, subset_size_r;
  logic        use_limit_r;
  logic [15:0] emit_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= 5'd16;
      subset_size_r <= 5'd1;
      use_limit_r   <= 1'b0;
      emit_limit_r  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT:  node_count_r  <= cfg_wdata[4:0];
        REG_SUBSET_SIZE: subset_size_r <= cfg_wdata[4:0];
        REG_USE_LIMIT:   use_limit_r   <= cfg_wdata[0];
        REG_EMIT_LIMIT:  emit_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured input word
  logic [1:0]  op_r;
  logic [3:0]  node_idx_r;
  logic [15:0] prob_in_r, wbw_in_r, rbw_in_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_tuser;
      node_idx_r <= in_tdata[3:0];
      prob_in_r  <= in_tdata[19:4];
      wbw_in_r   <= in_tdata[35:20];
      rbw_in_r   <= in_tdata[51:36];
    end
  end

  // Enumeration state
  logic                 exhausted_r;
  logic [15:0]          emitted_r;
  logic [MAX_NODES-1:0] pos_vld_r;
  logic [4:0]           wr_ptr_r;
  logic [AW-1:0]        wval_r;

  logic [4:0]  n_eff;
  logic        limit_hit;
  logic [15:0] emitted_nxt;
  logic        exhaust_nxt;

  always_comb begin
    n_eff       = (32'(node_count_r) > MAX_NODES) ? 5'(MAX_NODES) : node_count_r;
    limit_hit   = use_limit_r && (emitted_r >= emit_limit_r);
    emitted_nxt = (emitted_r < WORD_MAX) ? emitted_r + 16'd1 : emitted_r;
  end

  // Node table: {read_bw, write_bw, fail_prob}
  logic          tbl_we;
  logic [47:0]   tbl_rdata;
  logic [AW-1:0] s1_pos;

  assign tbl_we = cmd.tbl_wr && (32'(node_idx_r) < MAX_NODES);

  sewa_ram #(.WIDTH(48), .DEPTH(MAX_NODES)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(node_idx_r)),
    .wdata ({rbw_in_r, wbw_in_r, prob_in_r}),
    .raddr (s1_pos),
    .rdata (tbl_rdata)
  );

  // Position RAM; entries without a valid bit read as their own index
  logic [4:0]    rk_r;
  logic [AW-1:0] pos_rdata;

  sewa_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.pos_wr),
    .waddr (AW'(wr_ptr_r)),
    .wdata (wval_r),
    .raddr (AW'(rk_r)),
    .rdata (pos_rdata)
  );

  // Accumulate pipeline: issue, position, table, accumulate
  logic          issue;
  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [4:0]    s1_k_r;
  logic          s1_pvld_r;
  logic [AW-1:0] s2_idx_r;
  logic [15:0]   s3_p_r, s3_w_r, s3_r_r;
  logic [14:0]   s3_var_r;
  logic [15:0]   s3_mask_r;
  logic [32:0]   prod;
  logic [15:0]   mask_bits;
  logic [CMP_W-1:0] cmp_lhs, cmp_rhs;

  logic           cand_found_r;
  logic [4:0]     cand_i_r;
  logic [AW-1:0]  cand_v_r;

  logic [PSW-1:0] psum_r;
  logic [VSW-1:0] vsum_r;
  logic [15:0]    minw_r, minr_r, mask_r;

  assign issue  = cmd.acc_run && (rk_r < subset_size_r);
  assign s1_pos = s1_pvld_r ? pos_rdata : AW'(s1_k_r);

  always_comb begin
    cmp_lhs = CMP_W'(s1_pos) + CMP_W'(subset_size_r);
    cmp_rhs = CMP_W'(n_eff) + CMP_W'(s1_k_r);
    prod    = 33'(tbl_rdata[15:0]) * (33'(17'h10000) - 33'(tbl_rdata[15:0]));
    for (int b = 0; b < 16; b++) begin
      mask_bits[b] = (32'(s2_idx_r) == b);
    end
    exhaust_nxt = !cand_found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      rk_r         <= 5'd0;
      cand_found_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (cmd.acc_start) begin
        rk_r         <= 5'd0;
        cand_found_r <= 1'b0;
      end else begin
        if (issue) begin
          rk_r <= rk_r + 5'd1;
        end
        // keep the rightmost position that can still step forward
        if (s1_v_r && (cmp_lhs < cmp_rhs)) begin
          cand_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_k_r    <= rk_r;
      s1_pvld_r <= pos_vld_r[AW'(rk_r)];
    end
    if (s1_v_r && (cmp_lhs < cmp_rhs)) begin
      cand_i_r <= s1_k_r;
      cand_v_r <= s1_pos;
    end
    s2_idx_r  <= s1_pos;
    s3_p_r    <= tbl_rdata[15:0];
    s3_w_r    <= tbl_rdata[31:16];
    s3_r_r    <= tbl_rdata[47:32];
    s3_var_r  <= prod[30:16];
    s3_mask_r <= mask_bits;
    if (cmd.acc_start) begin
      psum_r <= '0;
      vsum_r <= '0;
      minw_r <= WORD_MAX;
      minr_r <= WORD_MAX;
      mask_r <= '0;
    end else if (s3_v_r) begin
      psum_r <= psum_r + PSW'(s3_p_r);
      vsum_r <= vsum_r + VSW'(s3_var_r);
      minw_r <= (s3_w_r < minw_r) ? s3_w_r : minw_r;
      minr_r <= (s3_r_r < minr_r) ? s3_r_r : minr_r;
      mask_r <= mask_r | s3_mask_r;
    end
  end

  // Enumeration control state and position rewrite pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exhausted_r <= 1'b0;
      emitted_r   <= 16'd0;
      pos_vld_r   <= '0;
    end else if (cmd.rewind) begin
      exhausted_r <= 1'b0;
      emitted_r   <= 16'd0;
      pos_vld_r   <= '0;
    end else begin
      if (cmd.advance) begin
        exhausted_r <= exhaust_nxt;
        emitted_r   <= emitted_nxt;
      end
      if (cmd.pos_wr) begin
        pos_vld_r[AW'(wr_ptr_r)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      wr_ptr_r <= cand_i_r;
      wval_r   <= AW'(cand_v_r + 1'b1);
    end else if (cmd.pos_wr) begin
      wr_ptr_r <= wr_ptr_r + 5'd1;
      wval_r   <= AW'(wval_r + 1'b1);
    end
  end

  // Result registers
  logic        res_has_r, res_fin_r;
  logic [15:0] res_mask_r, res_minw_r, res_minr_r, res_num_r;
  logic [19:0] res_psum_r;
  logic [18:0] res_vsum_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_res) begin
      res_has_r  <= 1'b0;
      res_fin_r  <= 1'b0;
      res_mask_r <= '0;
      res_psum_r <= '0;
      res_vsum_r <= '0;
      res_minw_r <= '0;
      res_minr_r <= '0;
      res_num_r  <= '0;
    end else if (cmd.advance) begin
      res_has_r  <= 1'b1;
      res_fin_r  <= exhaust_nxt || (use_limit_r && (emitted_nxt >= emit_limit_r));
      res_mask_r <= mask_r;
      res_psum_r <= (32'(psum_r) > 32'(PROB_SUM_MAX)) ? PROB_SUM_MAX : 20'(psum_r);
      res_vsum_r <= (32'(vsum_r) > 32'(VAR_SUM_MAX)) ? VAR_SUM_MAX : 19'(vsum_r);
      res_minw_r <= minw_r;
      res_minr_r <= minr_r;
      res_num_r  <= emitted_r;
    end
  end

  // Output register
  logic                  out_valid_r;
  logic                  out_free;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r, out_last_r;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.offer && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.offer && out_free) begin
      out_data_r <= {1'b0, res_num_r, res_minr_r, res_minw_r,
                     res_vsum_r, res_psum_r, res_mask_r};
      out_user_r <= res_has_r;
      out_last_r <= res_fin_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;
  assign out_tlast    = out_last_r;

  always_comb begin
    sta.op       = op_r;
    sta.next_ok  = (subset_size_r != 5'd0) && (subset_size_r <= n_eff) &&
                   !exhausted_r && !limit_hit;
    sta.acc_done = (rk_r >= subset_size_r) && !s1_v_r && !s2_v_r && !s3_v_r;
    sta.found    = cand_found_r;
    sta.wr_last  = (5'(wr_ptr_r + 5'd1) == subset_size_r);
    sta.out_free = out_free;
  end

endmodule

### rtl/subset_enumerator_with_aggregates_core.sv
// Subset enumerator core: load, rewind and next-subset words in, one result word out.
// Load, rewind, idle and empty next words pass straight from decode to the result; a next
// word with a subset runs the member pipeline (one position RAM read per member) plus (r - i)
// position writes when another subset follows. One word at a time; rst_n clears control.
// Positions read as their own index through per-entry valid bits, so there is no
// clearing pass; node table contents stay undefined until loaded.
`timescale 1ns / 1ps

module subset_enumerator_with_aggregates_core #(
  parameter int MAX_NODES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input word
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // node_index[3:0], fail_prob[19:4], write_bw[35:20], read_bw[51:36], zero pad
  input  logic [sewa_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode[1:0]
  input  logic [sewa_pkg::IN_USER_W-1:0]     in_tuser,
  // Result word
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // member_mask[15:0], prob_sum[35:16], variance_sum[54:36], min_write_bw[70:55],
  // min_read_bw[86:71], subset_number[102:87], zero pad[103]
  output logic [sewa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // has_subset[0]
  output logic [sewa_pkg::OUT_USER_W-1:0]    out_tuser,
  // is_final
  output logic                               out_tlast,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [sewa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sewa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import sewa_pkg::*;

  cmd_t cmd;
  sta_t sta;

  // Sequence each word: decode, walk members, rewrite positions, hand off result
  sewa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sta       (sta),
    .cmd       (cmd)
  );

  // Hold tables, positions, sums and the output register
  sewa_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sta        (sta),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/sewa_checker.sv
// Port-level checker for the subset enumerator core, bound to the top level.
// Depends on sewa_pkg for bus widths.
`timescale 1ns / 1ps

module sewa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sewa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sewa_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  import sewa_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A word without a subset carries all zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0) && !out_tlast)
    else $error("empty result carries nonzero fields");

  // Each variance term never exceeds its probability, so neither does the sum
  a_var_le_prob: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[54:36] <= out_tdata[35:16]))
    else $error("variance sum above probability sum");

  // One word in flight: ready drops right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

endmodule

bind subset_enumerator_with_aggregates_core sewa_checker u_sewa_checker (.*);

### verif/subset_enum_check_pkg.sv
// Checker package for the subset enumerator testbench: a cycle-free model of
// the node tables and the combination walk, plus the queue of due results.
// Depends on sewa_pkg for opcode, register codes and bus widths.
`timescale 1ns / 1ps

package subset_enum_check_pkg;

  import sewa_pkg::*;

  // Opcode 3 is not a defined command; the core answers it with an empty word.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int NODE_SLOTS = 16;

  typedef struct packed {
    logic        has_subset;
    logic [15:0] member_mask;
    logic [19:0] prob_sum;
    logic [18:0] variance_sum;
    logic [15:0] min_write_bw;
    logic [15:0] min_read_bw;
    logic [15:0] subset_number;
    logic        is_final;
  } subset_word_t;

  class combo_checker;
    logic [15:0] prob_tbl [NODE_SLOTS];
    logic [15:0] wbw_tbl [NODE_SLOTS];
    logic [15:0] rbw_tbl [NODE_SLOTS];
    int          pos [NODE_SLOTS];
    bit          spent;
    int          emitted;
    int          node_cfg;
    int          size_cfg;
    int          cap_on;
    int          cap_val;
    subset_word_t due_subsets [$];
    int          errors;

    function new();
      node_cfg = 16;
      size_cfg = 1;
      cap_on   = 0;
      cap_val  = 0;
      errors   = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      for (int k = 0; k < NODE_SLOTS; k++) pos[k] = k;
      spent   = 1'b0;
      emitted = 0;
    endfunction

    function bit cap_hit();
      return cap_on != 0 && emitted >= cap_val;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NODE_COUNT:  node_cfg = int'(val[4:0]);
        REG_SUBSET_SIZE: size_cfg = int'(val[4:0]);
        REG_USE_LIMIT:   cap_on   = int'(val[0]);
        REG_EMIT_LIMIT:  cap_val  = int'(val);
        default: ;
      endcase
    endfunction

    function int pending();
      return due_subsets.size();
    endfunction

    // Work out the result word caused by one accepted input word.
    function void note_word(logic [1:0] op, logic [3:0] idx, logic [15:0] p,
                            logic [15:0] w, logic [15:0] rd);
      subset_word_t res;
      int n, r, k, i, slot;
      int unsigned pv, psum, vsum;
      logic [15:0] minw, minr;
      res = '0;
      case (op)
        OP_LOAD: begin
          prob_tbl[idx] = p;
          wbw_tbl[idx]  = w;
          rbw_tbl[idx]  = rd;
        end
        OP_REWIND: restart_walk();
        OP_NEXT: begin
          n = (node_cfg > NODE_SLOTS) ? NODE_SLOTS : node_cfg;
          r = size_cfg;
          if (r != 0 && r <= n && !spent && !cap_hit()) begin
            psum = 0;
            vsum = 0;
            minw = 16'hFFFF;
            minr = 16'hFFFF;
            for (k = 0; k < r; k++) begin
              slot = pos[k] % NODE_SLOTS;
              pv   = prob_tbl[slot];
              res.member_mask[slot] = 1'b1;
              psum += pv;
              vsum += (pv * (32'd65536 - pv)) >> 16;
              if (wbw_tbl[slot] < minw) minw = wbw_tbl[slot];
              if (rbw_tbl[slot] < minr) minr = rbw_tbl[slot];
            end
            if (psum > PROB_SUM_MAX) psum = PROB_SUM_MAX;
            if (vsum > VAR_SUM_MAX) vsum = VAR_SUM_MAX;
            res.subset_number = emitted[15:0];
            if (emitted < 65535) emitted++;
            // Find the rightmost position that can still move, then repack.
            i = r - 1;
            while (i >= 0 && pos[i] >= n - r + i) i--;
            if (i < 0) begin
              spent = 1'b1;
            end else begin
              pos[i]++;
              for (k = i + 1; k < r; k++) pos[k] = pos[k-1] + 1;
            end
            res.has_subset   = 1'b1;
            res.prob_sum     = psum[19:0];
            res.variance_sum = vsum[18:0];
            res.min_write_bw = minw;
            res.min_read_bw  = minr;
            res.is_final     = spent || cap_hit();
          end
        end
        default: ;
      endcase
      due_subsets.push_back(res);
    endfunction

    function bit field_ok(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] d, logic has, logic fin);
      subset_word_t want;
      int bad;
      if (due_subsets.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %0h",
                 $time, d);
        errors++;
        return;
      end
      want = due_subsets.pop_front();
      bad = 0;
      bad += !field_ok("has_subset", want.has_subset, has);
      bad += !field_ok("member_mask", want.member_mask, d[15:0]);
      bad += !field_ok("prob_sum", want.prob_sum, d[35:16]);
      bad += !field_ok("variance_sum", want.variance_sum, d[54:36]);
      bad += !field_ok("min_write_bw", want.min_write_bw, d[70:55]);
      bad += !field_ok("min_read_bw", want.min_read_bw, d[86:71]);
      bad += !field_ok("subset_number", want.subset_number, d[102:87]);
      bad += !field_ok("is_final", want.is_final, fin);
      if (bad != 0) errors++;
    endfunction
  endclass

endpackage

### verif/subset_enumerator_with_aggregates_core_test.sv
// Top-level testbench for subset_enumerator_with_aggregates_core: drives load,
// rewind and next words with random gaps, rewrites the registers between phases
// and checks every result word against combo_checker (subset_enum_check_pkg).
`timescale 1ns / 1ps

module subset_enumerator_with_aggregates_core_test;

  import sewa_pkg::*;
  import subset_enum_check_pkg::*;

  localparam int ITEMS       = 1300;
  localparam int CALM_FROM   = 1150; // no idling on either side past this word
  localparam int STALL_LIMIT = 2000; // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 60;   // longest next walk plus margin

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  combo_checker sb = new();
  int items_sent = 0;
  bit calm = 1'b0;
  int out_hold = 0;
  int idle_cycles = 0;

  subset_enumerator_with_aggregates_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side: check each word taken at this edge, then pick the next
  // ready level, at times holding ready low for a stall burst.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata, out_tuser[0], out_tlast);
    end
    if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      out_hold   <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Random 16-bit field value, with the two extremes favored.
  function automatic logic [15:0] pick16();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one input word, optionally after an idle burst, and hold it until
  // taken. Valid stays high when the next word follows right away.
  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic [15:0] p, input logic [15:0] w,
                           input logic [15:0] rd);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, rd, w, p, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, idx, p, w, rd);
    items_sent++;
    if (items_sent >= CALM_FROM) calm <= 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Drop valid and wait until every result is back and the core takes words.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 || !in_tready) @(posedge clk);
  endtask

  // Random word: mostly next requests, with loads, rewinds and the
  // undefined opcode mixed in. Unused fields still carry random content.
  task automatic random_word();
    int sel;
    logic [1:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 62) op = OP_NEXT;
    else if (sel < 72) op = OP_REWIND;
    else if (sel < 94) op = OP_LOAD;
    else op = OP_IDLE;
    send_word(op, 4'($urandom_range(0, 15)), pick16(), pick16(), pick16());
  endtask

  // One phase: settle, write every register, maybe rewind, then a burst of words.
  // The first phases walk the corner settings; later ones are random and lean
  // toward small node counts so the walk runs to its end often.
  task automatic run_phase(input int ph);
    int nodes, size, cap_on, cap, eff, count, k, sel;
    bit restart;
    drain();
    restart = 1'b1;
    case (ph)
      0: begin nodes = 16; size = 16; cap_on = 0; cap = 0;     end
      1: begin nodes = 16; size = 8;  cap_on = 1; cap = 0;     end
      2: begin nodes = 1;  size = 1;  cap_on = 1; cap = 65535; end
      3: begin nodes = 16; size = 17; cap_on = 0; cap = 0;     end
      4: begin nodes = 5;  size = 0;  cap_on = 0; cap = 0;     end
      5: begin nodes = 31; size = 2;  cap_on = 1; cap = 3;     end
      6: begin nodes = 4;  size = 2;  cap_on = 0; cap = 0; restart = 1'b0; end
      default: begin
        sel = $urandom_range(0, 29);
        if (sel == 0) nodes = 0;
        else if (sel == 1) nodes = $urandom_range(17, 31);
        else if (sel < 6) nodes = 16;
        else if (sel < 8) nodes = 1;
        else if (sel < 20) nodes = $urandom_range(1, 6);
        else nodes = $urandom_range(1, 16);
        eff = (nodes > 16) ? 16 : nodes;
        sel = $urandom_range(0, 19);
        if (sel == 0) size = 0;
        else if (sel == 1) size = eff + 1;
        else if (sel == 2) size = (eff == 0) ? 1 : eff;
        else size = $urandom_range(1, (eff == 0) ? 1 : eff);
        cap_on = $urandom_range(0, 1);
        sel = $urandom_range(0, 9);
        if (sel == 0) cap = 0;
        else if (sel == 1) cap = 65535;
        else cap = $urandom_range(1, 40);
        restart = ($urandom_range(0, 4) != 0);
      end
    endcase
    write_reg(REG_NODE_COUNT, CFG_DATA_W'(nodes));
    write_reg(REG_SUBSET_SIZE, CFG_DATA_W'(size));
    write_reg(REG_USE_LIMIT, CFG_DATA_W'(cap_on));
    write_reg(REG_EMIT_LIMIT, CFG_DATA_W'(cap));
    cfg_we <= 1'b0;
    if (restart) send_word(OP_REWIND, 4'($urandom_range(0, 15)), pick16(), pick16(), pick16());
    count = $urandom_range(15, 50);
    for (k = 0; k < count && items_sent < ITEMS; k++) random_word();
  endtask

  initial begin
    int i, ph;
    logic [15:0] p, w, rd;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Load every slot first so no next request ever reads an unwritten node.
    // Slots 0..3 carry the field extremes; slot 2 also gives the largest
    // variance term.
    for (i = 0; i < 16; i++) begin
      p  = pick16();
      w  = pick16();
      rd = pick16();
      case (i)
        0: begin p = 16'h0000; w = 16'hFFFF; rd = 16'h1234; end
        1: begin p = 16'hFFFF; w = 16'h0000; rd = 16'h8001; end
        2: begin p = 16'h8000; w = 16'h7FFF; rd = 16'hFFFF; end
        3: begin p = 16'h0001; w = 16'h0001; rd = 16'h0000; end
        default: ;
      endcase
      send_word(OP_LOAD, 4'(i), p, w, rd);
    end
    // Undefined opcode, two single-node subsets at reset settings, a rewind
    // and the first subset again.
    send_word(OP_IDLE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_NEXT, 4'h0, 16'h0000, 16'h0000, 16'h0000);
    send_word(OP_NEXT, 4'hA, pick16(), pick16(), pick16());
    send_word(OP_REWIND, 4'h5, pick16(), pick16(), pick16());
    send_word(OP_NEXT, 4'h3, pick16(), pick16(), pick16());

    ph = 0;
    while (items_sent < ITEMS) begin
      run_phase(ph);
      ph++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
